// File: hw/rtl/reversible_queue_with_cut_core_defines.svh
// ----------------------------------------------------------------------------
// reversible queue with cut - assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_QUEUE_WITH_CUT_CORE_DEFINES_SVH
`define REVERSIBLE_QUEUE_WITH_CUT_CORE_DEFINES_SVH

// same-cycle implication
`define RQC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rqc assertion failed");

// next-cycle implication
`define RQC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rqc assertion failed");

`endif

// File: hw/rtl/rqc_pkg.sv
// ----------------------------------------------------------------------------
// rqc_pkg
// shared types and codes of the reversible queue with cut
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rqc_pkg;

   localparam int WORD_W = 32;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_EXTRACT = 3'd1,
      OP_SWAP    = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_CUT     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXTRACT_WAIT,
      S_CUT_SCAN
   } state_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      status_type status;
      logic       swapped;
   } res_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/reversible_queue_with_cut_core.sv
// ----------------------------------------------------------------------------
// reversible_queue_with_cut_core
// bounded double-ended queue of signed words with direction swap and cut
// ----------------------------------------------------------------------------
// One item is worked on at a time and each gives one result. Insert, swap,
// clear, a rejected insert or extract, a cut on an empty queue and an unused
// op give their result straight from the idle state; an extract waits for
// the registered read of the entry memory; a cut scans from the head through
// the single read port, one entry per cycle, until the first match or the
// last entry, and then keeps only the entries ahead of the match.
// The result sits in an output register; while a result waits there on a
// stalled receiver, the next item is held off. Entries come out of a memory
// with no reset; only entries written since the last clear are ever read.
`timescale 1ns / 1ps
`default_nettype none

module reversible_queue_with_cut_core
   import rqc_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_op,
   input  wire logic signed [WORD_W-1:0] req_data_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [WORD_W-1:0]      rsp_out_value,
   output logic      [1:0]               rsp_status,
   output logic      [CW-1:0]            rsp_occupancy,
   output logic                          rsp_swapped_flag
);

   res_ctl_type              res_ctl;
   logic signed [WORD_W-1:0] res_value;
   logic [CW-1:0]            res_occupancy;
   logic                     accept;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_value_ff;
   status_type               rsp_status_ff;
   logic [CW-1:0]            rsp_occ_ff;
   logic                     rsp_swapped_ff;

   assign req_stall = res_ctl.busy || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   rqc_engine #(
      .DEPTH(DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (req_op),
      .data_value    (req_data_value),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .res_ctl       (res_ctl),
      .res_value     (res_value),
      .res_occupancy (res_occupancy)
   );

   rqc_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid_in = res_ctl.done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_ctl.done) begin
         rsp_value_ff   <= res_value;
         rsp_status_ff  <= res_ctl.status;
         rsp_occ_ff     <= res_occupancy;
         rsp_swapped_ff <= res_ctl.swapped;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_swapped_flag = rsp_swapped_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rqc_ram.sv
// ----------------------------------------------------------------------------
// rqc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rqc_engine.sv
// ----------------------------------------------------------------------------
// rqc_engine
// pointer state, sequencer and memory access for the queue operations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqc_engine
   import rqc_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [2:0]               op,
   input  wire logic signed [WORD_W-1:0] data_value,
   output logic                          ram_we,
   output logic      [AW-1:0]            ram_waddr,
   output logic      [WORD_W-1:0]        ram_wdata,
   output logic                          ram_re,
   output logic      [AW-1:0]            ram_raddr,
   input  wire logic [WORD_W-1:0]        ram_rdata,
   output res_ctl_type                   res_ctl,
   output logic signed [WORD_W-1:0]      res_value,
   output logic      [CW-1:0]            res_occupancy
);

   localparam int SW = CW + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

   state_type                state_ff, state_in;
   logic [AW-1:0]            front_ff, front_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     swapped_ff, swapped_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic signed [WORD_W-1:0] key_ff, key_in;

   logic [AW-1:0] front_inc, front_dec, addr_inc, tail_slot, back_slot;
   logic [SW-1:0] tail_sum, back_sum;
   logic          match, scan_last, is_empty;

   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + AW'(1);
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - AW'(1);
   assign addr_inc  = (addr_ff == LAST_SLOT) ? '0 : addr_ff + AW'(1);

   // slot of front + count and of front + count - 1, wrapped once
   assign tail_sum  = SW'(front_ff) + SW'(count_ff);
   assign back_sum  = tail_sum - SW'(1);
   assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
   assign back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

   assign match     = (ram_rdata == key_ff);
   assign scan_last = ((idx_ff + CW'(1)) == count_ff);
   assign is_empty  = (count_ff == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && !is_empty) begin
               if (op_type'(op) == OP_EXTRACT) begin
                  state_in = S_EXTRACT_WAIT;
               end else if (op_type'(op) == OP_CUT) begin
                  state_in = S_CUT_SCAN;
               end
            end
         end
         S_EXTRACT_WAIT: state_in = S_IDLE;
         S_CUT_SCAN: begin
            if (match || scan_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      swapped_in     = swapped_ff;
      idx_in         = idx_ff;
      addr_in        = addr_ff;
      key_in         = key_ff;
      ram_we         = 1'b0;
      ram_waddr      = tail_slot;
      ram_wdata      = data_value;
      ram_re         = 1'b0;
      ram_raddr      = front_ff;
      res_ctl.busy   = (state_ff != S_IDLE);
      res_ctl.done   = 1'b0;
      res_ctl.status = ST_OK;
      res_value      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op_type'(op))
                  OP_INSERT: begin
                     res_ctl.done = 1'b1;
                     if (count_ff == DEPTH_C) begin
                        res_ctl.status = ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (swapped_ff) begin
                           front_in  = front_dec;
                           ram_waddr = front_dec;
                        end
                     end
                  end
                  OP_EXTRACT: begin
                     if (is_empty) begin
                        res_ctl.done   = 1'b1;
                        res_ctl.status = ST_EMPTY;
                     end else begin
                        ram_re   = 1'b1;
                        count_in = count_ff - CW'(1);
                        if (swapped_ff) begin
                           ram_raddr = back_slot;
                        end else begin
                           front_in = front_inc;
                        end
                     end
                  end
                  OP_SWAP: begin
                     res_ctl.done = 1'b1;
                     swapped_in   = ~swapped_ff;
                  end
                  OP_CLEAR: begin
                     res_ctl.done = 1'b1;
                     count_in     = '0;
                     front_in     = '0;
                  end
                  OP_CUT: begin
                     key_in = data_value;
                     if (is_empty) begin
                        res_ctl.done   = 1'b1;
                        res_ctl.status = ST_NOTFOUND;
                     end else begin
                        ram_re  = 1'b1;
                        addr_in = front_ff;
                        idx_in  = '0;
                     end
                  end
                  default: res_ctl.done = 1'b1;
               endcase
            end
         end
         S_EXTRACT_WAIT: begin
            res_ctl.done = 1'b1;
            res_value    = ram_rdata;
         end
         S_CUT_SCAN: begin
            if (match) begin
               res_ctl.done = 1'b1;
               count_in     = idx_ff;
            end else if (scan_last) begin
               res_ctl.done   = 1'b1;
               res_ctl.status = ST_NOTFOUND;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = addr_inc;
               addr_in   = addr_inc;
               idx_in    = idx_ff + CW'(1);
            end
         end
         default: ;
      endcase
      res_ctl.swapped = swapped_in;
   end

   assign res_occupancy = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         front_ff   <= '0;
         count_ff   <= '0;
         swapped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         count_ff   <= count_in;
         swapped_ff <= swapped_in;
      end
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
      key_ff  <= key_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/rqc_checker.sv
// ----------------------------------------------------------------------------
// rqc_checker
// port-level checks of the reversible queue with cut, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "reversible_queue_with_cut_core_defines.svh"

module rqc_checker
   import rqc_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [2:0]               req_op,
   input wire logic signed [WORD_W-1:0] req_data_value,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [WORD_W-1:0] rsp_out_value,
   input wire logic [1:0]               rsp_status,
   input wire logic [CW-1:0]            rsp_occupancy,
   input wire logic                     rsp_swapped_flag
);

   logic full_rsp, empty_rsp, empty_ok, rsp_wait, req_wait;
   logic [WORD_W+CW+2:0] rsp_payload;
   logic [WORD_W+2:0]    req_payload;

   assign full_rsp    = rsp_valid && (status_type'(rsp_status) == ST_FULL);
   assign empty_rsp   = rsp_valid && (status_type'(rsp_status) == ST_EMPTY);
   assign empty_ok    = (rsp_occupancy == '0) && (rsp_out_value == '0);
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign req_wait    = req_valid && req_stall;
   assign rsp_payload = {rsp_out_value, rsp_status, rsp_occupancy, rsp_swapped_flag};
   assign req_payload = {req_op, req_data_value};

   `RQC_ASSERT_IMPLY(a_occ_bound, clock, reset, rsp_valid, rsp_occupancy <= CW'(DEPTH))
   `RQC_ASSERT_IMPLY(a_full_occ, clock, reset, full_rsp, rsp_occupancy == CW'(DEPTH))
   `RQC_ASSERT_IMPLY(a_empty_rsp, clock, reset, empty_rsp, empty_ok)
   `RQC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_payload))
   `RQC_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_payload))

endmodule

bind reversible_queue_with_cut_core rqc_checker #(.DEPTH(DEPTH)) u_rqc_checker (.*);

`default_nettype wire

// File: dv/tb_reversible_queue_with_cut_core.sv
// ----------------------------------------------------------------------------
// tb_reversible_queue_with_cut_core
// self-checking bench for the reversible queue with cut. A directed opening
// covers the empty, full-free corner cases, both directions, cut at the head
// and in the middle, clear and the unused op codes. Random sequences of
// inserts, extracts, cuts, swaps and clears follow. Each accepted item is
// run through a scoreboard that mirrors the queue, and every result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reversible_queue_with_cut_core;
   import rqc_pkg::*;

   localparam int DEPTH = 16;
   localparam int CLK_HALF = 5;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 825;
   localparam int HOLD_AT = 120;
   localparam int HOLD_CYCLES = 300;
   localparam int BURST_FROM = 110;
   localparam int BURST_TO = 260;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 500000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [1:0]               status;
      logic [4:0]               occupancy;
      logic                     swapped;
   } outcome_t;

   class rqc_scoreboard;
      logic signed [WORD_W-1:0] slots [DEPTH];
      int unsigned head;
      int unsigned fill;
      bit          swapped;
      outcome_t    awaited [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned status_seen [4];
      int unsigned peak_fill;

      function new();
         head = 0;
         fill = 0;
         swapped = 0;
         mismatches = 0;
         checked = 0;
         peak_fill = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function logic signed [WORD_W-1:0] value_at(int unsigned offset);
         return slots[(head + offset) % DEPTH];
      endfunction

      // queue behavior for one accepted item
      function void note_request(logic [2:0] op, logic signed [WORD_W-1:0] data);
         outcome_t    o;
         int unsigned i;
         o.value = '0;
         o.status = ST_OK;
         case (op)
            OP_INSERT: begin
               if (fill >= DEPTH) begin
                  o.status = ST_FULL;
               end else if (swapped) begin
                  head = (head + DEPTH - 1) % DEPTH;
                  slots[head] = data;
                  fill++;
               end else begin
                  slots[(head + fill) % DEPTH] = data;
                  fill++;
               end
            end
            OP_EXTRACT: begin
               if (fill == 0) begin
                  o.status = ST_EMPTY;
               end else if (swapped) begin
                  o.value = slots[(head + fill - 1) % DEPTH];
                  fill--;
               end else begin
                  o.value = slots[head];
                  head = (head + 1) % DEPTH;
                  fill--;
               end
            end
            OP_SWAP: begin
               swapped = !swapped;
            end
            OP_CLEAR: begin
               fill = 0;
               head = 0;
            end
            OP_CUT: begin
               o.status = ST_NOTFOUND;
               for (i = 0; i < fill; i++) begin
                  if (slots[(head + i) % DEPTH] == data) begin
                     fill = i;
                     o.status = ST_OK;
                     break;
                  end
               end
            end
            default: begin
            end
         endcase
         o.occupancy = 5'(fill);
         o.swapped = swapped;
         status_seen[o.status]++;
         if (fill > peak_fill) peak_fill = fill;
         awaited.push_back(o);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
      endfunction

      function void check_response(logic signed [WORD_W-1:0] value, logic [1:0] status,
                                   logic [4:0] occupancy, logic swapped_flag);
         outcome_t o;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected result value %0d status %0d occupancy %0d swapped %0b",
                           value, status, occupancy, swapped_flag));
            return;
         end
         o = awaited.pop_front();
         checked++;
         if (value !== o.value)
            flag($sformatf("result %0d out_value exp %0d got %0d", checked, o.value, value));
         if (status !== o.status)
            flag($sformatf("result %0d status exp %0d got %0d", checked, o.status, status));
         if (occupancy !== o.occupancy)
            flag($sformatf("result %0d occupancy exp %0d got %0d", checked, o.occupancy,
                           occupancy));
         if (swapped_flag !== o.swapped)
            flag($sformatf("result %0d swapped_flag exp %0b got %0b", checked, o.swapped,
                           swapped_flag));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_op = OP_INSERT;
   logic signed [WORD_W-1:0] req_data_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [WORD_W-1:0] rsp_out_value;
   logic [1:0]               rsp_status;
   logic [4:0]               rsp_occupancy;
   logic                     rsp_swapped_flag;

   rqc_scoreboard sb = new();
   int unsigned   items_sent = 0;
   int unsigned   cycle_count = 0;

   reversible_queue_with_cut_core #(.DEPTH(DEPTH)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_swapped_flag (rsp_swapped_flag)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_out_value, rsp_status, rsp_occupancy, rsp_swapped_flag);
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (items_sent >= BURST_FROM && items_sent < BURST_TO) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom;
      if (r < 60) return $urandom_range(1, 6);
      if (r < 75) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            default: return -32'sd1;
         endcase
      end
      if (sb.fill > 0) return sb.value_at($urandom_range(0, sb.fill - 1));
      return $urandom;
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_cut_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (sb.fill > 0 && r < 60) return sb.value_at($urandom_range(0, sb.fill - 1));
      if (sb.fill > 0 && r < 72) return sb.value_at(0);
      if (r < 85) return $urandom_range(1, 6);
      return $urandom;
   endfunction

   task automatic send_item(input logic [2:0] op, input logic signed [WORD_W-1:0] data);
      int unsigned gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_data_value <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, data);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_burst(input logic [2:0] op, input int unsigned count,
                             inout int unsigned done);
      repeat (count) begin
         if (op == OP_CUT) send_item(op, pick_cut_value());
         else send_item(op, pick_value());
         done++;
      end
   endtask

   task automatic run_directed();
      send_item(OP_EXTRACT, '0);
      send_item(OP_CUT, 32'sd5);
      send_item(OP_SWAP, '0);
      send_item(OP_EXTRACT, -32'sd1);
      send_item(OP_SWAP, '0);
      send_item(OP_INSERT, 32'sh7fff_ffff);
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_INSERT, '0);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sh5555_5555);
      send_item(OP_INSERT, 32'shaaaa_aaaa);
      send_item(OP_EXTRACT, '0);
      send_item(OP_SWAP, '0);
      send_item(OP_INSERT, 32'sd42);
      send_item(OP_EXTRACT, '0);
      send_item(OP_CUT, 32'sd12345);
      send_item(OP_CUT, -32'sd1);
      send_item(OP_CUT, 32'sd42);
      send_item(OP_SWAP, '0);
      send_item(OP_FIRST_UNUSED, 32'sh7fff_ffff);
      send_item(OP_FIRST_UNUSED + 3'd1, -32'sd1);
      send_item(OP_FIRST_UNUSED + 3'd2, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sd7);
      send_item(OP_CLEAR, '0);
      send_item(OP_EXTRACT, '0);
   endtask

   task automatic run_random();
      int unsigned done;
      int unsigned r;
      done = 0;
      while (done < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 33) begin
            send_burst(OP_INSERT, $urandom_range(1, 18), done);
         end else if (r < 55) begin
            send_burst(OP_EXTRACT, $urandom_range(1, 18), done);
         end else if (r < 68) begin
            send_burst(OP_CUT, 1, done);
         end else if (r < 77) begin
            send_burst(OP_SWAP, 1, done);
         end else if (r < 81) begin
            send_burst(OP_CLEAR, 1, done);
         end else if (r < 84) begin
            // leaves the queue unchanged, not counted
            send_item(OP_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom);
         end else begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 3))
                  0: send_burst(OP_INSERT, 1, done);
                  1: send_burst(OP_EXTRACT, 1, done);
                  2: send_burst(OP_SWAP, 1, done);
                  default: send_burst(OP_CUT, 1, done);
               endcase
            end
         end
      end
   endtask

   initial begin : receiver
      int unsigned run;
      bit          held;
      held = 0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && items_sent >= HOLD_AT) begin
            // long hold-off so the block backs up into its input
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1;
         end else if ($urandom_range(0, 99) < 55) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 9) < 8) run = $urandom_range(1, 3);
            else run = $urandom_range(10, 40);
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin : sender
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d items sent, %0d results checked, peak occupancy %0d",
               items_sent, sb.checked, sb.peak_fill);
      $display("status counts: ok %0d, empty %0d, full %0d, not found %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
               sb.status_seen[ST_FULL], sb.status_seen[ST_NOTFOUND]);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rqc_pkg.sv
hw/rtl/rqc_ram.sv
hw/rtl/rqc_engine.sv
hw/rtl/reversible_queue_with_cut_core.sv
hw/rtl/rqc_checker.sv
dv/tb_reversible_queue_with_cut_core.sv
